// ===== src/mwtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mwtg_pkg
// shared types, register map and the quarter-wave sine table for the
// multi-waveform tone generator
// ----------------------------------------------------------------------------
package mwtg_pkg;

  localparam int SineDepth     = 256;
  localparam int SineDepthBits = $clog2(SineDepth);
  localparam int FullScale     = 32767;
  localparam int UnityQ15      = 32768;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  localparam int RegAddrBits = 4;

  typedef enum logic [1:0] {
    RegPhaseInc   = 2'd0,
    RegWaveShape  = 2'd1,
    RegAmplitude  = 2'd2,
    RegFrameCount = 2'd3
  } reg_index_e;

  typedef enum logic [1:0] {
    WaveSine     = 2'd0,
    WaveSquare   = 2'd1,
    WaveTriangle = 2'd2,
    WaveSawtooth = 2'd3
  } wave_shape_e;

  typedef logic [15:0] sine_table_t [SineDepth];

  // one item on its way from the phase accumulator to the shaper
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [31:0] phase;
  } phase_item_t;

  // Taylor series in Q30 up to the x^19 term, evaluated at elaboration
  function automatic sine_table_t sine_table_init();
    sine_table_t        tbl;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    for (int i = 0; i < SineDepth; i++) begin
      x    = (HalfPiQ30 * 64'(i)) / 64'(SineDepth);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 9; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      r = (64'(sum) * 64'(FullScale) + (64'd1 << 29)) >> 30;
      if (r > 64'(FullScale)) begin
        r = 64'(FullScale);
      end
      tbl[i] = r[15:0];
    end
    return tbl;
  endfunction

endpackage

// ===== src/mwtg_shape.sv =====
// ----------------------------------------------------------------------------
// mwtg_shape
// turns a 32-bit phase word into a full-scale sine, square, triangle or
// sawtooth value in -32767..32767
// ----------------------------------------------------------------------------
module mwtg_shape (
  input  mwtg_pkg::wave_shape_e wave_shape_i,
  input  logic [31:0]           phase_i,
  output logic signed [15:0]    value_o
);
  import mwtg_pkg::*;

  localparam sine_table_t SineTable = sine_table_init();

  logic [SineDepthBits-1:0] sin_k;
  logic [SineDepthBits-1:0] sin_k_mirror;
  logic [15:0]              sin_mag;
  logic signed [15:0]       sin_val;

  logic signed [32:0] tri_d;
  logic signed [47:0] tri_p;
  logic signed [47:0] tri_q;
  logic signed [32:0] saw_d;
  logic signed [47:0] saw_p;
  logic signed [47:0] saw_q;

  // sine: quarter-wave lookup, mirrored in odd quadrants, negated in the second half of the cycle
  assign sin_k        = phase_i[29 -: SineDepthBits];
  assign sin_k_mirror = SineDepthBits'(0) - sin_k;

  always_comb begin
    if (phase_i[30]) begin
      sin_mag = (sin_k == '0) ? 16'(FullScale) : SineTable[sin_k_mirror];
    end else begin
      sin_mag = SineTable[sin_k];
    end
    sin_val = phase_i[31] ? -$signed(sin_mag) : $signed(sin_mag);
  end

  // triangle and sawtooth: times 32767 by shift and subtract, truncated toward zero
  always_comb begin
    if (phase_i[31]) begin
      tri_d = 33'sh0C0000000 - $signed({1'b0, phase_i});
    end else begin
      tri_d = $signed({1'b0, phase_i}) - 33'sh040000000;
    end
    tri_p = (48'(tri_d) <<< 15) - 48'(tri_d);
    tri_q = (tri_p + (tri_p[47] ? 48'sd1073741823 : 48'sd0)) >>> 30;

    saw_d = $signed({1'b0, phase_i}) - 33'sh080000000;
    saw_p = (48'(saw_d) <<< 15) - 48'(saw_d);
    saw_q = (saw_p + (saw_p[47] ? 48'sd2147483647 : 48'sd0)) >>> 31;
  end

  always_comb begin
    unique case (wave_shape_i)
      WaveSine:     value_o = sin_val;
      WaveSquare:   value_o = phase_i[31] ? -16'sd32767 : 16'sd32767;
      WaveTriangle: value_o = tri_q[15:0];
      WaveSawtooth: value_o = saw_q[15:0];
      default:      value_o = '0;
    endcase
  end

endmodule

// ===== src/multi_waveform_tone_generator.sv =====
// path: an accepted producing tick reaches the output through the phase, shape and output registers
// throughput: one tick per cycle while the input is not stalled, set by the phase accumulator loop
// pipeline: accumulator -> phase register -> shape register -> scaled output register
// reset (asynchronous, active low) clears phase, remaining frames and all stage
// valids, and loads the configuration registers with their defaults
// ----------------------------------------------------------------------------
// multi_waveform_tone_generator
// direct digital synthesis tone source with sine, square, triangle and
// sawtooth shapes, Q1.15 gain and a per-tone frame count
// ----------------------------------------------------------------------------
module multi_waveform_tone_generator #(
  parameter int PHASE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mwtg_pkg::RegAddrBits-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              start_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [15:0]                left_sample_o,
  output logic signed [15:0]                right_sample_o,
  output logic                              last_frame_o
);
  import mwtg_pkg::*;

  localparam int WideBits  = PHASE_BITS + 32;
  localparam int UpShift   = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
  localparam int DownShift = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

  // configuration
  logic [31:0]  phase_inc_q;
  wave_shape_e  wave_shape_q;
  logic [15:0]  amplitude_q;
  logic [31:0]  frame_count_q;
  logic         cfg_write;
  reg_index_e   cfg_index;

  // tone state
  logic [PHASE_BITS-1:0] phase_q, phase_d, phase_eff, phase_inc_al;
  logic [31:0]           frames_left_q, frames_left_d, frames_eff;
  logic [WideBits-1:0]   inc_wide, phase_wide;
  logic                  produce;
  logic                  in_accept;

  // pipeline
  phase_item_t        s1_q, s1_d;
  logic               s2_valid_q, s2_last_q;
  logic signed [15:0] s2_value_q;
  logic signed [15:0] shape_value;
  logic               out_valid_q, out_last_q;
  logic signed [15:0] out_sample_q;
  logic               rdy1, rdy2, rdy3;

  logic [16:0]        gain;
  logic signed [33:0] scaled;
  logic signed [33:0] scaled_div;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_index)
      RegPhaseInc:   prdata = phase_inc_q;
      RegWaveShape:  prdata = {30'd0, wave_shape_q};
      RegAmplitude:  prdata = {16'd0, amplitude_q};
      RegFrameCount: prdata = frame_count_q;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q   <= 32'd42852281;
      wave_shape_q  <= WaveSine;
      amplitude_q   <= 16'd24576;
      frame_count_q <= 32'd22050;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegPhaseInc:   phase_inc_q   <= pwdata;
        RegWaveShape:  wave_shape_q  <= wave_shape_e'(pwdata[1:0]);
        RegAmplitude:  amplitude_q   <= pwdata[15:0];
        RegFrameCount: frame_count_q <= pwdata;
        default:       ;
      endcase
    end
  end

  // stage enables, a stage moves when it is empty or the next one moves
  assign rdy3       = !out_valid_q || !out_stall_i;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_q.valid || rdy2;
  assign in_stall_o = !rdy1;
  assign in_accept  = in_valid_i && rdy1;

  // align the 32-bit increment to the accumulator width (the phase is aligned back to 32 bits below)
  assign inc_wide     = (WideBits'(phase_inc_q) << UpShift) >> DownShift;
  assign phase_inc_al = inc_wide[PHASE_BITS-1:0];

  always_comb begin
    phase_eff  = start_req_i ? '0 : phase_q;
    frames_eff = start_req_i ? frame_count_q : frames_left_q;
    produce    = (frames_eff != '0);
    phase_wide = (WideBits'(phase_eff) >> UpShift) << DownShift;

    phase_d       = phase_eff;
    frames_left_d = frames_eff;
    if (produce) begin
      phase_d       = phase_eff + phase_inc_al;
      frames_left_d = frames_eff - 32'd1;
    end

    s1_d.valid = produce;
    s1_d.last  = (frames_eff == 32'd1);
    s1_d.phase = phase_wide[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= '0;
      frames_left_q <= '0;
    end else if (in_accept) begin
      phase_q       <= phase_d;
      frames_left_q <= frames_left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      if (rdy1) begin
        s1_q.valid <= in_accept && s1_d.valid;
      end
      if (in_accept) begin
        s1_q.last  <= s1_d.last;
        s1_q.phase <= s1_d.phase;
      end
    end
  end

  mwtg_shape u_shape (
    .wave_shape_i (wave_shape_q),
    .phase_i      (s1_q.phase),
    .value_o      (shape_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (rdy2) begin
      s2_valid_q <= s1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_value_q <= shape_value;
      s2_last_q  <= s1_q.last;
    end
  end

  // gain above unity acts as unity, then truncate toward zero
  always_comb begin
    gain       = (amplitude_q > 16'(UnityQ15 - 1)) ? 17'(UnityQ15) : {1'b0, amplitude_q};
    scaled     = 34'(s2_value_q) * $signed({17'd0, gain});
    scaled_div = (scaled + (scaled[33] ? 34'sd32767 : 34'sd0)) >>> 15;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy3) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      out_sample_q <= scaled_div[15:0];
      out_last_q   <= s2_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = out_sample_q;
  assign right_sample_o = out_sample_q;
  assign last_frame_o   = out_last_q;

endmodule

// ===== src/mwtg_checker.sv =====
// ----------------------------------------------------------------------------
// mwtg_checker
// port-level checks for the multi-waveform tone generator
// ----------------------------------------------------------------------------
module mwtg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [mwtg_pkg::RegAddrBits-1:0]  paddr,
  input logic [31:0]                       pwdata,
  input logic [31:0]                       prdata,
  input logic                              pready,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              start_req_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [15:0]                left_sample_o,
  input logic signed [15:0]                right_sample_o,
  input logic                              last_frame_o
);

  // stereo frame carries the same word on both channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_sample_o == right_sample_o))
    else $error("left and right samples differ");

  // scaled sample never reaches the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_sample_o != 16'sh8000))
    else $error("sample outside full scale");

  // a stalled word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output word dropped under stall");

  // a stalled word keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(left_sample_o) && $stable(last_frame_o)))
    else $error("output payload changed under stall");

endmodule

bind multi_waveform_tone_generator mwtg_checker u_mwtg_checker (.*);
